// ----- hdl/xoxf_pkg.sv -----
package xoxf_pkg;

    localparam int DEPTH = 8;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int UPPER_W = 4;
    localparam int LOWER_W = 3;
    localparam int FILL_W = 4;
    localparam int CMP_W = (CNT_W > UPPER_W) ? CNT_W : UPPER_W;
    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = UPPER_W;

    localparam logic [UPPER_W-1:0] UPPER_RESET = 4'd8;
    localparam logic [LOWER_W-1:0] LOWER_RESET = 3'd2;

    typedef logic [1:0] t_flow;
    localparam t_flow FLOW_NONE = 2'd0;
    localparam t_flow FLOW_XON  = 2'd1;
    localparam t_flow FLOW_XOFF = 2'd2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 1'b1;

    localparam logic [BYTE_W-1:0] CH_LF        = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'd13;
    localparam logic [BYTE_W-1:0] CH_EOF       = 8'd26;
    localparam logic [BYTE_W-1:0] CH_PRINTABLE = 8'd32;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    function automatic logic is_consumable(input logic [BYTE_W-1:0] b);
        return (b >= CH_PRINTABLE) || (b == CH_CR) || (b == CH_LF) || (b == CH_EOF);
    endfunction

endpackage

// ----- hdl/xoxf_ram.sv -----
module xoxf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/xon_xoff_receive_fifo.sv -----
// Channel   Handshake                   Payload
// command   i_start / o_busy            i_cmd, i_rx_byte
// result    o_done (one-cycle strobe)   o_pop_valid, o_pop_byte, o_consumable,
//                                       o_flow_send, o_overflow, o_fill_level
// config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A push, or a pop from an empty FIFO, has its result strobed in the next cycle.
// A pop with data waits in S_READ for the registered read of the byte RAM;
// o_busy is high while in S_READ, and the result strobes after it.
// i_rst_n is synchronous; the byte RAM keeps no reset, entries are read only once pushed.
// The receiver cannot stall: o_done marks each result for exactly one cycle.
module xon_xoff_receive_fifo
    import xoxf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_cmd,
    input  logic [BYTE_W-1:0]     i_rx_byte,
    output logic                  o_done,
    output logic                  o_pop_valid,
    output logic [BYTE_W-1:0]     o_pop_byte,
    output logic                  o_consumable,
    output logic [1:0]            o_flow_send,
    output logic                  o_overflow,
    output logic [FILL_W-1:0]     o_fill_level,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state               r_state, n_state;
    logic [PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_send_ok, n_send_ok;
    t_flow                r_pend_flow, n_pend_flow;
    logic [UPPER_W-1:0]   r_upper;
    logic [LOWER_W-1:0]   r_lower;

    logic                 r_done, n_done;
    logic                 r_pop_valid, n_pop_valid;
    logic [BYTE_W-1:0]    r_pop_byte, n_pop_byte;
    logic                 r_consumable, n_consumable;
    t_flow                r_flow, n_flow;
    logic                 r_overflow, n_overflow;
    logic [FILL_W-1:0]    r_fill, n_fill;

    logic                 accept;
    logic                 ram_we;
    logic [BYTE_W-1:0]    ram_rdata;
    logic [CNT_W-1:0]     cnt_new;
    logic [CMP_W-1:0]     cnt_ext;

    assign accept = i_start && (r_state == S_IDLE);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    xoxf_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wr_ptr),
        .i_wdata(i_rx_byte),
        .i_raddr(r_rd_ptr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_count      = r_count;
        n_send_ok    = r_send_ok;
        n_pend_flow  = r_pend_flow;
        n_done       = 1'b0;
        n_pop_valid  = r_pop_valid;
        n_pop_byte   = r_pop_byte;
        n_consumable = r_consumable;
        n_flow       = r_flow;
        n_overflow   = r_overflow;
        n_fill       = r_fill;
        ram_we       = 1'b0;
        cnt_new      = r_count;
        cnt_ext      = CMP_W'(r_count);

        case (r_state)
            S_READ: begin
                // read data lands now; finish the pop
                n_state      = S_IDLE;
                n_done       = 1'b1;
                n_pop_valid  = 1'b1;
                n_pop_byte   = ram_rdata;
                n_consumable = is_consumable(ram_rdata);
                n_flow       = r_pend_flow;
                n_overflow   = 1'b0;
                n_fill       = cnt_ext[FILL_W-1:0];
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_PUSH) begin
                        n_overflow = 1'b0;
                        if (r_count >= CNT_W'(DEPTH)) begin
                            n_overflow = 1'b1;
                        end else begin
                            ram_we   = 1'b1;
                            n_wr_ptr = next_slot(r_wr_ptr);
                            cnt_new  = r_count + 1'b1;
                        end
                        n_count = cnt_new;
                        cnt_ext = CMP_W'(cnt_new);
                        n_flow  = FLOW_NONE;
                        if ((cnt_ext >= CMP_W'(r_upper)) && r_send_ok) begin
                            n_send_ok = 1'b0;
                            n_flow    = FLOW_XOFF;
                        end
                        n_done       = 1'b1;
                        n_pop_valid  = 1'b0;
                        n_pop_byte   = '0;
                        n_consumable = 1'b0;
                        n_fill       = cnt_ext[FILL_W-1:0];
                    end else if (r_count != '0) begin
                        cnt_new     = r_count - 1'b1;
                        cnt_ext     = CMP_W'(cnt_new);
                        n_count     = cnt_new;
                        n_rd_ptr    = next_slot(r_rd_ptr);
                        n_pend_flow = FLOW_NONE;
                        if ((cnt_ext <= CMP_W'(r_lower)) && !r_send_ok) begin
                            n_send_ok   = 1'b1;
                            n_pend_flow = FLOW_XON;
                        end
                        n_state = S_READ;
                    end else begin
                        n_done       = 1'b1;
                        n_pop_valid  = 1'b0;
                        n_pop_byte   = '0;
                        n_consumable = 1'b0;
                        n_flow       = FLOW_NONE;
                        n_overflow   = 1'b0;
                        n_fill       = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_count   <= '0;
            r_send_ok <= 1'b1;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_ptr  <= n_rd_ptr;
            r_wr_ptr  <= n_wr_ptr;
            r_count   <= n_count;
            r_send_ok <= n_send_ok;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_flow  <= n_pend_flow;
        r_pop_valid  <= n_pop_valid;
        r_pop_byte   <= n_pop_byte;
        r_consumable <= n_consumable;
        r_flow       <= n_flow;
        r_overflow   <= n_overflow;
        r_fill       <= n_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= UPPER_RESET;
            r_lower <= LOWER_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_UPPER: r_upper <= i_cfg_data[UPPER_W-1:0];
                CFG_LOWER: r_lower <= i_cfg_data[LOWER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_busy       = (r_state == S_READ);
    assign o_cfg_ready  = 1'b1;
    assign o_done       = r_done;
    assign o_pop_valid  = r_pop_valid;
    assign o_pop_byte   = r_pop_byte;
    assign o_consumable = r_consumable;
    assign o_flow_send  = r_flow;
    assign o_overflow   = r_overflow;
    assign o_fill_level = r_fill;

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> !o_busy)
        else $error("read wait lasted more than one cycle");

    a_busy_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> o_done && o_pop_valid)
        else $error("pop finished without a result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_xoff_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_flow_send == FLOW_XOFF)) |-> !r_send_ok)
        else $error("XOFF sent while sending still allowed");

    a_pop_goes_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_POP) && (r_count != '0)) |=> o_busy)
        else $error("pop with data did not wait for the RAM");

endmodule
